// ----- rtl/bhtb_pkg.sv -----
// ----------------------------------------------------------------------------
// bhtb_pkg
// Shared types and constants for the bracketed hex text to byte converter.
// ----------------------------------------------------------------------------
package bhtb_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // characters with a meaning to the parser
    localparam logic [20:0] CP_OPEN  = 21'h00005B;
    localparam logic [20:0] CP_CLOSE = 21'h00005D;
    localparam logic [20:0] CP_SPACE = 21'h000020;

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    // command queue between parser and emitter
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One parsed character: up to four data bytes (left-aligned, first byte
    // in the top bits), then at most one error or end result.
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  n_data;
        logic        err;
        logic        fin;
        logic [15:0] pos;
    } t_cmd;

    // hex digit decode: valid flag in bit 4, value in bits 3:0
    function automatic logic [4:0] hex_decode(input logic [20:0] cp);
        logic [4:0] r;
        r = 5'd0;
        if (cp >= 21'h30 && cp <= 21'h39) begin
            r = {1'b1, cp[3:0]};
        end else if ((cp >= 21'h41 && cp <= 21'h46) || (cp >= 21'h61 && cp <= 21'h66)) begin
            r = {1'b1, cp[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- rtl/bhtb_front.sv -----
// ----------------------------------------------------------------------------
// bhtb_front
// Character parser: tracks bracket mode, digit pairing and character index,
// and turns each character into at most one emit command.
// ----------------------------------------------------------------------------
module bhtb_front import bhtb_pkg::*; #(
    parameter int MAX_CHARS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [20:0] i_code_point,
    input  logic        i_last_char,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [1:0] MODE_OUT  = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_IN   = 2'd2;
    localparam logic [1:0] MODE_ERR  = 2'd3;

    localparam int          CAP_INT = (MAX_CHARS - 1 > 65535) ? 65535 : (MAX_CHARS - 1);
    localparam logic [15:0] IDX_CAP = 16'(CAP_INT);

    logic [1:0]  r_mode,   n_mode;
    logic        r_parity, n_parity;
    logic [3:0]  r_hi,     n_hi;
    logic [15:0] r_idx,    n_idx;

    logic        accept;
    logic        emit;
    logic        err;
    logic [4:0]  hex;
    t_cmd        cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign hex     = hex_decode(i_code_point);

    always_comb begin
        n_mode   = r_mode;
        n_parity = r_parity;
        n_hi     = r_hi;
        n_idx    = r_idx;
        emit     = 1'b0;
        err      = 1'b0;
        cmd      = '0;

        if (r_mode != MODE_ERR) begin
            if (i_code_point == CP_OPEN) begin
                if (r_mode == MODE_OUT) begin
                    n_mode = MODE_OPEN;
                end else if (r_mode == MODE_OPEN) begin
                    n_mode = MODE_OUT;
                    emit   = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end else if (i_code_point == CP_CLOSE) begin
                if (r_mode == MODE_OUT) begin
                    emit = 1'b1;
                end else if (r_parity) begin
                    err = 1'b1;
                end else begin
                    n_mode = MODE_OUT;
                end
            end else if (r_mode != MODE_OUT) begin
                if (hex[4]) begin
                    n_mode = MODE_IN;
                    if (r_parity) begin
                        cmd.bytes  = {r_hi, hex[3:0] & NIBBLE_MASK, 24'd0};
                        cmd.n_data = 3'd1;
                        n_parity   = 1'b0;
                    end else begin
                        n_hi     = hex[3:0];
                        n_parity = 1'b1;
                    end
                end else if (i_code_point == CP_SPACE) begin
                    n_mode = MODE_IN;
                end else begin
                    err = 1'b1;
                end
            end else begin
                emit = 1'b1;
            end

            // big-endian, width chosen by magnitude
            if (emit) begin
                n_parity = 1'b0;
                n_hi     = 4'd0;
                if (i_code_point[20:16] != 5'd0) begin
                    cmd.bytes  = {11'd0, i_code_point};
                    cmd.n_data = 3'd4;
                end else if (i_code_point[15:8] != 8'd0) begin
                    cmd.bytes  = {i_code_point[15:0], 16'd0};
                    cmd.n_data = 3'd2;
                end else begin
                    cmd.bytes  = {i_code_point[7:0], 24'd0};
                    cmd.n_data = 3'd1;
                end
            end

            if (err) begin
                cmd.err = 1'b1;
                cmd.pos = r_idx;
                n_mode  = MODE_ERR;
            end

            if (r_idx < IDX_CAP) begin
                n_idx = r_idx + 16'd1;
            end

            cmd.fin = i_last_char && !err;
        end

        // end of text: back to the initial parser state
        if (i_last_char) begin
            n_mode   = MODE_OUT;
            n_parity = 1'b0;
            n_hi     = 4'd0;
            n_idx    = 16'd0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.n_data != 3'd0 || cmd.err || cmd.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OUT;
            r_parity <= 1'b0;
            r_hi     <= 4'd0;
            r_idx    <= 16'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_parity <= n_parity;
            r_hi     <= n_hi;
            r_idx    <= n_idx;
        end
    end

endmodule

// ----- rtl/bhtb_fifo.sv -----
// ----------------------------------------------------------------------------
// bhtb_fifo
// Small command queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module bhtb_fifo import bhtb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd             r_slot [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/bhtb_back.sv -----
// ----------------------------------------------------------------------------
// bhtb_back
// Byte emitter: walks the results of the head command, one per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bhtb_back import bhtb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_error_position,
    output logic        o_last_of_run
);

    logic [2:0]  r_sel, n_sel;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic [15:0] r_pos;
    logic        r_last;

    logic [2:0]  total;
    logic        is_final;
    logic        load;
    logic        is_data;
    logic [7:0]  sel_byte;

    assign total    = i_head.n_data + {2'd0, i_head.err | i_head.fin};
    assign is_final = (r_sel == total - 3'd1);
    assign load     = i_head_valid && (!r_valid || i_ready);
    assign o_pop    = load && is_final;
    assign is_data  = (r_sel < i_head.n_data);

    always_comb begin
        case (r_sel[1:0])
            2'd0:    sel_byte = i_head.bytes[31:24];
            2'd1:    sel_byte = i_head.bytes[23:16];
            2'd2:    sel_byte = i_head.bytes[15:8];
            default: sel_byte = i_head.bytes[7:0];
        endcase
    end

    always_comb begin
        n_sel = r_sel;
        if (o_pop) begin
            n_sel = 3'd0;
        end else if (load) begin
            n_sel = r_sel + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_sel <= n_sel;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload: hold while the output is stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= is_final;
            if (is_data) begin
                r_kind <= KIND_DATA;
                r_byte <= sel_byte;
                r_pos  <= 16'd0;
            end else if (i_head.err) begin
                r_kind <= KIND_ERROR;
                r_byte <= 8'd0;
                r_pos  <= i_head.pos;
            end else begin
                r_kind <= KIND_END;
                r_byte <= 8'd0;
                r_pos  <= 16'd0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_byte;
    assign o_error_position = r_pos;
    assign o_last_of_run    = r_last;

endmodule

// ----- rtl/bracket_hex_text_to_bytes.sv -----
// One character per cycle while each yields at most one result and the output
// is not stalled; the emitter sends the results of a character one at a time,
// so a character with several results holds the emitter until all are out.
// A four-entry command queue lets the parser run ahead of the emitter.
// Reset (i_rst_n low, synchronous) clears the parser state, queue and output valid.
// ----------------------------------------------------------------------------
// bracket_hex_text_to_bytes
// Converts a stream of code points with bracketed hex groups into bytes.
// ----------------------------------------------------------------------------
module bracket_hex_text_to_bytes import bhtb_pkg::*; #(
    parameter int MAX_CHARS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] error_position
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    logic        push, pop, q_full, head_valid;
    t_cmd        push_cmd, head_cmd;
    logic [7:0]  data_byte;
    logic [15:0] error_position;

    bhtb_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_code_point (s_axis_tdata[20:0]),
        .i_last_char  (s_axis_tlast),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    bhtb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    bhtb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (head_valid),
        .i_head           (head_cmd),
        .o_pop            (pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_kind           (m_axis_tuser),
        .o_data_byte      (data_byte),
        .o_error_position (error_position),
        .o_last_of_run    (m_axis_tlast)
    );

    assign m_axis_tdata = {error_position, data_byte};

endmodule

// ----- dv/bhtb_checker.sv -----
// ----------------------------------------------------------------------------
// bhtb_checker
// Watches both stream channels of the bracketed hex converter, predicts the
// result transactions of every accepted character and compares them in order.
// ----------------------------------------------------------------------------
module bhtb_checker import bhtb_pkg::*; #(
    parameter int MAX_CHARS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        i_s_axis_tlast,   // last_char
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,   // [7:0] data_byte, [23:8] error_position
    input  logic [1:0]  i_m_axis_tuser,   // [1:0] kind
    input  logic        i_m_axis_tlast,   // last_of_run
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_CAP = (MAX_CHARS - 1 > 65535) ? 65535 : MAX_CHARS - 1;

    localparam logic [20:0] CP_DIGIT_0 = 21'h30;
    localparam logic [20:0] CP_DIGIT_9 = 21'h39;
    localparam logic [20:0] CP_UPPER_A = 21'h41;
    localparam logic [20:0] CP_UPPER_F = 21'h46;
    localparam logic [20:0] CP_LOWER_A = 21'h61;
    localparam logic [20:0] CP_LOWER_F = 21'h66;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_OPENED,
        MODE_GROUP,
        MODE_FAULT
    } t_parse_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] err_pos;
        logic        run_end;
    } t_conv_result;

    t_parse_mode  mode;
    logic         odd_digit;
    logic [3:0]   hi_nibble;
    logic [15:0]  char_pos;
    t_conv_result step_q[$];
    t_conv_result expected_q[$];
    int           mismatches = 0;
    int           checked = 0;

    function automatic void clear_parser();
        mode      = MODE_TEXT;
        odd_digit = 1'b0;
        hi_nibble = 4'h0;
        char_pos  = 16'd0;
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] dbyte,
                                       input logic [15:0] pos);
        t_conv_result r;
        r.kind      = kind;
        r.data_byte = dbyte;
        r.err_pos   = pos;
        r.run_end   = 1'b0;
        step_q.push_back(r);
    endfunction

    // big-endian, width picked by magnitude
    function automatic void add_char_bytes(input logic [20:0] cp);
        logic [31:0] w;
        w = {11'd0, cp};
        if (w[31:16] != 16'd0) begin
            add_result(KIND_DATA, w[31:24], 16'd0);
            add_result(KIND_DATA, w[23:16], 16'd0);
        end
        if (w[31:8] != 24'd0) begin
            add_result(KIND_DATA, w[15:8], 16'd0);
        end
        add_result(KIND_DATA, w[7:0], 16'd0);
        odd_digit = 1'b0;
        hi_nibble = 4'h0;
    endfunction

    // Advance the parser by one character and queue the results it yields.
    function automatic void parse_char(input logic [20:0] cp, input logic eot);
        logic [20:0] off;
        logic        fault;
        fault = 1'b0;
        step_q.delete();
        if (mode == MODE_FAULT) begin
            // swallow everything up to the end of the text
            if (eot) begin
                clear_parser();
            end
            return;
        end
        // hex decode: bit 4 flags a digit, bits 3:0 carry its value
        off = 21'd0;
        if (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_9) begin
            off = cp - CP_DIGIT_0 + 21'd16;
        end else if (cp >= CP_UPPER_A && cp <= CP_UPPER_F) begin
            off = cp - CP_UPPER_A + 21'd26;
        end else if (cp >= CP_LOWER_A && cp <= CP_LOWER_F) begin
            off = cp - CP_LOWER_A + 21'd26;
        end

        if (cp == CP_OPEN) begin
            case (mode)
                MODE_TEXT: begin
                    mode = MODE_OPENED;
                end
                MODE_OPENED: begin
                    mode = MODE_TEXT;
                    add_char_bytes(cp);
                end
                default: begin
                    fault = 1'b1;
                end
            endcase
        end else if (cp == CP_CLOSE) begin
            if (mode == MODE_TEXT) begin
                add_char_bytes(cp);
            end else if (odd_digit) begin
                fault = 1'b1;
            end else begin
                mode = MODE_TEXT;
            end
        end else if (mode != MODE_TEXT) begin
            if (off[4]) begin
                mode = MODE_GROUP;
                if (odd_digit) begin
                    add_result(KIND_DATA, {hi_nibble, off[3:0]}, 16'd0);
                    odd_digit = 1'b0;
                end else begin
                    hi_nibble = off[3:0];
                    odd_digit = 1'b1;
                end
            end else if (cp == CP_SPACE) begin
                mode = MODE_GROUP;
            end else begin
                fault = 1'b1;
            end
        end else begin
            add_char_bytes(cp);
        end

        if (fault) begin
            add_result(KIND_ERROR, 8'd0, char_pos);
            mode = MODE_FAULT;
        end
        if (char_pos < INDEX_CAP) begin
            char_pos = char_pos + 16'd1;
        end
        if (eot) begin
            if (!fault) begin
                add_result(KIND_END, 8'd0, 16'd0);
            end
            clear_parser();
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].run_end = 1'b1;
        end
        foreach (step_q[i]) begin
            expected_q.push_back(step_q[i]);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_conv_result got;
        t_conv_result want;
        logic         bad;
        if (!i_rst_n) begin
            clear_parser();
            expected_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_char(i_s_axis_tdata[20:0], i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.kind      = i_m_axis_tuser;
                got.data_byte = i_m_axis_tdata[7:0];
                got.err_pos   = i_m_axis_tdata[23:8];
                got.run_end   = i_m_axis_tlast;
                checked++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: unexpected result kind=%0d byte=%02h pos=%0d last=%0b",
                                 got.kind, got.data_byte, got.err_pos, got.run_end);
                    end
                end else begin
                    want = expected_q.pop_front();
                    bad  = (got.kind != want.kind) || (got.data_byte != want.data_byte) ||
                           (got.err_pos != want.err_pos) || (got.run_end != want.run_end);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("tb: result %0d expected kind=%0d byte=%02h pos=%0d last=%0b",
                                     checked, want.kind, want.data_byte, want.err_pos,
                                     want.run_end);
                            $display("tb: result %0d got      kind=%0d byte=%02h pos=%0d last=%0b",
                                     checked, got.kind, got.data_byte, got.err_pos,
                                     got.run_end);
                        end
                    end
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives text streams into the bracketed hex converter: a few directed texts
// for the corner cases and random texts under three idle mixes. The checker
// does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bhtb_pkg::*;

    localparam logic [20:0] CP_DIGIT_0 = 21'h30;
    localparam logic [20:0] CP_UPPER_A = 21'h41;
    localparam logic [20:0] CP_LOWER_A = 21'h61;
    localparam logic [20:0] CP_LOWER_G = 21'h67;
    localparam int          ITEMS_PER_PHASE = 97;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;   // [20:0] code_point, [23:21] zero
    logic        s_axis_tlast = 1'b0;    // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] data_byte, [23:8] error_position
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;           // last_of_run

    int          mismatches;
    int          pending;
    int          checked;
    int          src_gap_pct = 12;
    int          sink_stall_pct = 57;
    int          n_texts = 0;
    int          n_chars = 0;
    logic [20:0] text_q[$];

    bracket_hex_text_to_bytes u_dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .m_axis_tlast
    );

    bhtb_checker u_checker (
        .i_clk,
        .i_rst_n,
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [20:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return CP_DIGIT_0 + 21'(v);
        end
        return (upper ? CP_UPPER_A : CP_LOWER_A) + 21'(v) - 21'd10;
    endfunction

    function automatic logic [20:0] rand_hex();
        return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
    endfunction

    // neither a hex digit, a space nor a bracket
    function automatic logic [20:0] stray_char();
        case ($urandom_range(7))
            0: return 21'h2F;   // just below the digits
            1: return 21'h3A;   // just above the digits
            2: return 21'h40;
            3: return 21'h47;
            4: return 21'h60;
            5: return CP_LOWER_G;
            6: return 21'h000000;
            default: return 21'($urandom_range(21'h80, 21'h10FFFF));
        endcase
    endfunction

    function automatic logic [20:0] noise_char();
        case ($urandom_range(5))
            0: return CP_OPEN;
            1: return CP_CLOSE;
            2: return CP_SPACE;
            3: return rand_hex();
            4: return stray_char();
            default: return 21'($urandom_range(21'h10FFFF));
        endcase
    endfunction

    function automatic void add_hex_pairs(input int pairs);
        repeat (pairs) begin
            if ($urandom_range(2) == 0) begin
                text_q.push_back(CP_SPACE);
            end
            text_q.push_back(rand_hex());
            if ($urandom_range(5) == 0) begin
                text_q.push_back(CP_SPACE);
            end
            text_q.push_back(rand_hex());
        end
    endfunction

    // Mostly well-formed texts with random content, then broken ones and noise.
    function automatic void make_text();
        int          style;
        logic [20:0] cp;
        text_q.delete();
        style = $urandom_range(99);
        if (style < 15) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(noise_char());
            return;
        end
        repeat ((style < 70) ? $urandom_range(1, 5) : $urandom_range(0, 2)) begin
            case ($urandom_range(5))
                0: cp = 21'($urandom_range(21'h20, 21'h7E));
                1: cp = 21'($urandom_range(21'hFF));
                2: cp = 21'($urandom_range(21'h100, 21'hFFFF));
                3: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                default: cp = CP_OPEN;
            endcase
            if (cp != CP_OPEN) begin
                text_q.push_back(cp);
            end else if ($urandom_range(2) == 0) begin
                // escaped bracket
                text_q.push_back(CP_OPEN);
                text_q.push_back(CP_OPEN);
            end else begin
                text_q.push_back(CP_OPEN);
                add_hex_pairs($urandom_range(0, 3));
                if ($urandom_range(3) == 0) begin
                    text_q.push_back(CP_SPACE);
                end
                text_q.push_back(CP_CLOSE);
            end
        end
        if (style < 70) begin
            if ($urandom_range(5) == 0) begin
                // stop inside an open group, sometimes on a lone nibble
                text_q.push_back(CP_OPEN);
                add_hex_pairs($urandom_range(0, 2));
                if ($urandom_range(1) == 0) begin
                    text_q.push_back(rand_hex());
                end
            end
        end else begin
            text_q.push_back(CP_OPEN);
            case ($urandom_range(3))
                0: begin
                    add_hex_pairs($urandom_range(0, 2));
                    text_q.push_back(rand_hex());
                    text_q.push_back(CP_CLOSE);
                end
                1: begin
                    text_q.push_back(CP_SPACE);
                    add_hex_pairs($urandom_range(0, 2));
                    text_q.push_back(CP_OPEN);
                end
                2: begin
                    add_hex_pairs($urandom_range(0, 2));
                    text_q.push_back(stray_char());
                end
                default: begin
                    text_q.push_back(stray_char());
                end
            endcase
            // whatever follows the fault is ignored until the end of the text
            repeat ($urandom_range(0, 4)) text_q.push_back(noise_char());
        end
    endfunction

    task automatic send_text();
        foreach (text_q[i]) begin
            while ($urandom_range(99) < src_gap_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {3'b000, text_q[i]};
            s_axis_tlast  <= (i == text_q.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) begin
                @(posedge i_clk);
            end
            n_chars++;
        end
        n_texts++;
    endtask

    task automatic run_random(input int n_items);
        int first;
        first = n_chars;
        while (n_chars - first < n_items) begin
            make_text();
            send_text();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver stalls often
        src_gap_pct    = 12;
        sink_stall_pct = 57;
        text_q = '{21'h000000};
        send_text();
        text_q = '{21'h0000FF, 21'h000100, 21'h00FFFF, 21'h010000, 21'h10FFFF};
        send_text();
        // lone close, escaped open, empty group
        text_q = '{CP_CLOSE, CP_OPEN, CP_OPEN, CP_OPEN, CP_CLOSE};
        send_text();
        // both cases of digits, text ends on an unpaired nibble
        text_q = '{CP_OPEN, hex_char(4'd0, 1'b0), hex_char(4'd9, 1'b0),
                   hex_char(4'd10, 1'b0), hex_char(4'd15, 1'b1),
                   hex_char(4'd10, 1'b1), hex_char(4'd15, 1'b0), hex_char(4'd3, 1'b0)};
        send_text();
        // close after an odd digit count, on the last character
        text_q = '{CP_OPEN, hex_char(4'd1, 1'b0), CP_CLOSE};
        send_text();
        // open bracket inside a group
        text_q = '{CP_OPEN, CP_SPACE, CP_OPEN};
        send_text();
        // foreign character inside a group, trailing character ignored
        text_q = '{CP_OPEN, CP_LOWER_G, hex_char(4'd1, 1'b0)};
        send_text();
        run_random(ITEMS_PER_PHASE);

        src_gap_pct    = 57;
        sink_stall_pct = 12;
        run_random(ITEMS_PER_PHASE);

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        run_random(ITEMS_PER_PHASE);

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("tb: %0d texts, %0d characters sent, %0d results checked",
                 n_texts, n_chars, checked);
        $display("tb: directed corners and random texts under three idle mixes covered");
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bhtb_pkg.sv
rtl/bhtb_front.sv
rtl/bhtb_fifo.sv
rtl/bhtb_back.sv
rtl/bracket_hex_text_to_bytes.sv
dv/bhtb_checker.sv
dv/tb_top.sv
